// ===== rtl/triangle_tangent_binormal_assert.svh =====
// ----------------------------------------------------------------------------
// Tangent/binormal block assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BINORMAL_ASSERT_SVH
`define TRIANGLE_TANGENT_BINORMAL_ASSERT_SVH

// same-cycle implication
`define TTB_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define TTB_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg
// Widths, state codes and vertex phase codes of the tangent/binormal block.
// ----------------------------------------------------------------------------
`default_nettype none

package ttb_pkg;

  localparam int POS_W = 16;
  localparam int TEX_W = 16;
  localparam int OUT_W = 16;

  // signed difference of two inputs, and its magnitude
  localparam int DIF_W = ((POS_W > TEX_W) ? POS_W : TEX_W) + 1;
  localparam int MAG_W = DIF_W - 1;
  localparam int PRD_W = 2 * MAG_W;
  localparam int ACC_W = PRD_W + 2;

  // normalization
  localparam int NORM_BITS = 30;
  localparam int NM_W = ((ACC_W - 1) > NORM_BITS) ? (ACC_W - 1) : NORM_BITS;
  localparam int MUL_W = (MAG_W > NORM_BITS) ? MAG_W : NORM_BITS;
  localparam int SUM_W = 2 * NORM_BITS + 2;
  localparam int RT_W = SUM_W / 2;
  localparam int QUO_W = 16;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_NORM_LOAD,
    ST_NORM_SHIFT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/triangle_tangent_binormal.sv =====
// Sequence: the first and second vertex of a face are only held in registers.
// The third vertex starts a face computation: 14 serial products (only 2 on a zero
// determinant), then per vector a load, normalizing shifts, 3 squares, a square
// root and 3 divides.
// Throughput: one face per computation; in_ready is low until its result is registered.
// Reset: synchronous, clears the vertex phase, sequencer and output valid.
// ----------------------------------------------------------------------------
// triangle_tangent_binormal
// Per-face tangent and binormal from a triangle-list vertex stream,
// normalized to Q1.14 with bit-serial multiply, square root and divide.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_binormal (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ttb_pkg::POS_W-1:0]   pos_x,
  input  logic signed [ttb_pkg::POS_W-1:0]   pos_y,
  input  logic signed [ttb_pkg::POS_W-1:0]   pos_z,
  input  logic        [ttb_pkg::TEX_W-1:0]   tex_u,
  input  logic        [ttb_pkg::TEX_W-1:0]   tex_v,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ttb_pkg::OUT_W-1:0]   tangent_x,
  output logic signed [ttb_pkg::OUT_W-1:0]   tangent_y,
  output logic signed [ttb_pkg::OUT_W-1:0]   tangent_z,
  output logic signed [ttb_pkg::OUT_W-1:0]   binormal_x,
  output logic signed [ttb_pkg::OUT_W-1:0]   binormal_y,
  output logic signed [ttb_pkg::OUT_W-1:0]   binormal_z,
  output logic                               degenerate
);

`include "triangle_tangent_binormal_assert.svh"

  localparam int DW = ttb_pkg::DIF_W;
  localparam int MG = ttb_pkg::MAG_W;
  localparam int PW = ttb_pkg::PRD_W;
  localparam int AW = ttb_pkg::ACC_W;
  localparam int NB = ttb_pkg::NORM_BITS;
  localparam int NW = ttb_pkg::NM_W;
  localparam int MW = ttb_pkg::MUL_W;
  localparam int SW = ttb_pkg::SUM_W;
  localparam int RW = ttb_pkg::RT_W;
  localparam int QW = ttb_pkg::QUO_W;
  localparam int OW = ttb_pkg::OUT_W;

  ttb_pkg::state_t state, state_next;
  ttb_pkg::phase_t phase;

  // held vertices, already widened
  logic signed [DW-1:0] v0_x, v0_y, v0_z, v0_u, v0_v;
  logic signed [DW-1:0] v1_x, v1_y, v1_z, v1_u, v1_v;
  logic signed [DW-1:0] in_x, in_y, in_z, in_u, in_v;

  // face operands
  logic signed [DW-1:0] e1_x, e1_y, e1_z, e2_x, e2_y, e2_z;
  logic signed [DW-1:0] du1, dv1, du2, dv2;

  logic [3:0]            op;
  logic signed [AW-1:0]  acc, det;
  logic signed [AW-1:0]  tan_x, tan_y, tan_z, bin_x, bin_y, bin_z;
  logic                  vsel;
  logic [1:0]            idx;
  logic [NW-1:0]         nm0, nm1, nm2;
  logic                  ns0, ns1, ns2;
  logic [SW-1:0]         sum;
  logic [RW-1:0]         len;
  logic                  deg;
  logic signed [OW-1:0]  tq0, tq1, tq2, bq0, bq1, bq2;

  logic in_xfer;
  assign in_ready = (state == ttb_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign in_x = DW'(pos_x);
  assign in_y = DW'(pos_y);
  assign in_z = DW'(pos_z);
  assign in_u = DW'(tex_u);
  assign in_v = DW'(tex_v);

  // operand select for the product sequence
  logic signed [DW-1:0] opa, opb;
  logic [DW-1:0]        nega, negb;
  logic [MG-1:0]        maga, magb;
  logic                 psign;

  always_comb begin
    case (op)
      4'd0:    begin opa = du1; opb = dv2;  end
      4'd1:    begin opa = du2; opb = dv1;  end
      4'd2:    begin opa = dv2; opb = e1_x; end
      4'd3:    begin opa = dv1; opb = e2_x; end
      4'd4:    begin opa = dv2; opb = e1_y; end
      4'd5:    begin opa = dv1; opb = e2_y; end
      4'd6:    begin opa = dv2; opb = e1_z; end
      4'd7:    begin opa = dv1; opb = e2_z; end
      4'd8:    begin opa = du1; opb = e2_x; end
      4'd9:    begin opa = du2; opb = e1_x; end
      4'd10:   begin opa = du1; opb = e2_y; end
      4'd11:   begin opa = du2; opb = e1_y; end
      4'd12:   begin opa = du1; opb = e2_z; end
      4'd13:   begin opa = du2; opb = e1_z; end
      default: begin opa = '0;  opb = '0;   end
    endcase
  end

  assign nega  = -opa;
  assign negb  = -opb;
  assign maga  = opa[DW-1] ? nega[MG-1:0] : opa[MG-1:0];
  assign magb  = opb[DW-1] ? negb[MG-1:0] : opb[MG-1:0];
  assign psign = opa[DW-1] ^ opb[DW-1];

  // current normalized magnitude
  logic [NB-1:0] m_cur;
  always_comb begin
    case (idx)
      2'd0:    m_cur = nm0[NB-1:0];
      2'd1:    m_cur = nm1[NB-1:0];
      default: m_cur = nm2[NB-1:0];
    endcase
  end

  logic n_cur;
  always_comb begin
    case (idx)
      2'd0:    n_cur = ns0;
      2'd1:    n_cur = ns1;
      default: n_cur = ns2;
    endcase
  end

  // serial units
  logic              sq_phase;
  logic              mul_start, sqrt_start, div_start;
  logic              mul_done, sqrt_done, div_done;
  logic [MW-1:0]     mul_a, mul_b;
  logic [2*MW-1:0]   mul_p;
  logic [RW-1:0]     sqrt_r;
  logic [QW-1:0]     div_q;

  assign sq_phase = (state == ttb_pkg::ST_SQ_GO) || (state == ttb_pkg::ST_SQ_WAIT);
  assign mul_a    = sq_phase ? MW'(m_cur) : MW'(maga);
  assign mul_b    = sq_phase ? MW'(m_cur) : MW'(magb);

  ttb_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .done   (mul_done),
    .prod   (mul_p)
  );

  ttb_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum),
    .done     (sqrt_done),
    .root     (sqrt_r)
  );

  ttb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (m_cur),
    .den   (len),
    .done  (div_done),
    .quo   (div_q)
  );

  // product accumulation
  logic signed [AW-1:0] term, term_s, acc_new;
  assign term    = AW'(mul_p[PW-1:0]);
  assign term_s  = psign ? -term : term;
  assign acc_new = op[0] ? (acc - term_s) : term_s;

  // normalization view of the selected vector
  logic signed [AW-1:0] c0, c1, c2;
  logic [AW-1:0]        a0, a1, a2;
  assign c0 = vsel ? bin_x : tan_x;
  assign c1 = vsel ? bin_y : tan_y;
  assign c2 = vsel ? bin_z : tan_z;
  assign a0 = c0[AW-1] ? -c0 : c0;
  assign a1 = c1[AW-1] ? -c1 : c1;
  assign a2 = c2[AW-1] ? -c2 : c2;

  logic [NW-1:0] orv;
  logic          too_wide, too_narrow, vec_zero;
  assign orv        = nm0 | nm1 | nm2;
  assign vec_zero   = (orv == '0);
  assign too_wide   = |orv[NW-1:NB];
  assign too_narrow = !orv[NB-1];

  // round half away from zero and apply sign
  logic [QW:0]          rsum;
  logic [QW-1:0]        rq;
  logic signed [OW-1:0] qv;
  assign rsum = (QW + 1)'(div_q) + 1'b1;
  assign rq   = rsum[QW:1];
  assign qv   = n_cur ? -OW'(rq) : OW'(rq);

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state)
      ttb_pkg::ST_IDLE: begin
        if (in_xfer && phase == ttb_pkg::PH_THIRD) state_next = ttb_pkg::ST_MUL_GO;
      end
      ttb_pkg::ST_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = ttb_pkg::ST_MUL_WAIT;
      end
      ttb_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          if (op == 4'd1 && acc_new == '0) state_next = ttb_pkg::ST_FINISH;
          else if (op == 4'd13)            state_next = ttb_pkg::ST_NORM_LOAD;
          else                             state_next = ttb_pkg::ST_MUL_GO;
        end
      end
      ttb_pkg::ST_NORM_LOAD: begin
        state_next = ttb_pkg::ST_NORM_SHIFT;
      end
      ttb_pkg::ST_NORM_SHIFT: begin
        if (vec_zero)                        state_next = ttb_pkg::ST_FINISH;
        else if (!too_wide && !too_narrow)   state_next = ttb_pkg::ST_SQ_GO;
      end
      ttb_pkg::ST_SQ_GO: begin
        mul_start  = 1'b1;
        state_next = ttb_pkg::ST_SQ_WAIT;
      end
      ttb_pkg::ST_SQ_WAIT: begin
        if (mul_done) state_next = (idx == 2'd2) ? ttb_pkg::ST_SQRT_GO : ttb_pkg::ST_SQ_GO;
      end
      ttb_pkg::ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_next = ttb_pkg::ST_SQRT_WAIT;
      end
      ttb_pkg::ST_SQRT_WAIT: begin
        if (sqrt_done) state_next = ttb_pkg::ST_DIV_GO;
      end
      ttb_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ttb_pkg::ST_DIV_WAIT;
      end
      ttb_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (idx != 2'd2) state_next = ttb_pkg::ST_DIV_GO;
          else if (!vsel)  state_next = ttb_pkg::ST_NORM_LOAD;
          else             state_next = ttb_pkg::ST_FINISH;
        end
      end
      ttb_pkg::ST_FINISH: begin
        if (out_free) state_next = ttb_pkg::ST_IDLE;
      end
      default: state_next = ttb_pkg::ST_IDLE;
    endcase
  end

  // vertex phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ttb_pkg::PH_FIRST;
    end else if (in_xfer) begin
      case (phase)
        ttb_pkg::PH_FIRST:  phase <= ttb_pkg::PH_SECOND;
        ttb_pkg::PH_SECOND: phase <= ttb_pkg::PH_THIRD;
        default:            phase <= ttb_pkg::PH_FIRST;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      v0_x <= '0; v0_y <= '0; v0_z <= '0; v0_u <= '0; v0_v <= '0;
      v1_x <= '0; v1_y <= '0; v1_z <= '0; v1_u <= '0; v1_v <= '0;
    end else if (in_xfer) begin
      if (phase == ttb_pkg::PH_SECOND) begin
        v1_x <= in_x; v1_y <= in_y; v1_z <= in_z; v1_u <= in_u; v1_v <= in_v;
      end else if (phase != ttb_pkg::PH_THIRD) begin
        v0_x <= in_x; v0_y <= in_y; v0_z <= in_z; v0_u <= in_u; v0_v <= in_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ttb_pkg::ST_IDLE: begin
        e1_x <= v1_x - v0_x;
        e1_y <= v1_y - v0_y;
        e1_z <= v1_z - v0_z;
        e2_x <= in_x - v0_x;
        e2_y <= in_y - v0_y;
        e2_z <= in_z - v0_z;
        du1  <= v1_u - v0_u;
        dv1  <= v1_v - v0_v;
        du2  <= in_u - v0_u;
        dv2  <= in_v - v0_v;
        op   <= '0;
        vsel <= 1'b0;
        deg  <= 1'b0;
      end
      ttb_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          acc <= acc_new;
          op  <= op + 1'b1;
          case (op)
            4'd1: begin
              det <= acc_new;
              if (acc_new == '0) deg <= 1'b1;
            end
            4'd3:  tan_x <= acc_new;
            4'd5:  tan_y <= acc_new;
            4'd7:  tan_z <= acc_new;
            4'd9:  bin_x <= acc_new;
            4'd11: bin_y <= acc_new;
            4'd13: bin_z <= acc_new;
            default: ;
          endcase
        end
      end
      ttb_pkg::ST_NORM_LOAD: begin
        nm0 <= NW'(a0[AW-2:0]);
        nm1 <= NW'(a1[AW-2:0]);
        nm2 <= NW'(a2[AW-2:0]);
        ns0 <= c0[AW-1] ^ det[AW-1];
        ns1 <= c1[AW-1] ^ det[AW-1];
        ns2 <= c2[AW-1] ^ det[AW-1];
      end
      ttb_pkg::ST_NORM_SHIFT: begin
        idx <= '0;
        sum <= '0;
        if (vec_zero) begin
          deg <= 1'b1;
        end else if (too_wide) begin
          // truncate one bit at a time
          nm0 <= nm0 >> 1;
          nm1 <= nm1 >> 1;
          nm2 <= nm2 >> 1;
        end else if (too_narrow) begin
          nm0 <= nm0 << 1;
          nm1 <= nm1 << 1;
          nm2 <= nm2 << 1;
        end
      end
      ttb_pkg::ST_SQ_WAIT: begin
        if (mul_done) begin
          sum <= sum + SW'(mul_p);
          idx <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
        end
      end
      ttb_pkg::ST_SQRT_WAIT: begin
        if (sqrt_done) len <= sqrt_r;
      end
      ttb_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          idx <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
          if (idx == 2'd2) vsel <= 1'b1;
          case ({vsel, idx})
            3'b000:  tq0 <= qv;
            3'b001:  tq1 <= qv;
            3'b010:  tq2 <= qv;
            3'b100:  bq0 <= qv;
            3'b101:  bq1 <= qv;
            3'b110:  bq2 <= qv;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ttb_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ttb_pkg::ST_FINISH && out_free) begin
      tangent_x  <= deg ? '0 : tq0;
      tangent_y  <= deg ? '0 : tq1;
      tangent_z  <= deg ? '0 : tq2;
      binormal_x <= deg ? '0 : bq0;
      binormal_y <= deg ? '0 : bq1;
      binormal_z <= deg ? '0 : bq2;
      degenerate <= deg;
    end
  end

  `TTB_ASSERT_NOW(a_mul_done_waited, mul_done,
    state == ttb_pkg::ST_MUL_WAIT || state == ttb_pkg::ST_SQ_WAIT,
    "multiplier finished outside a wait state")
  `TTB_ASSERT_NOW(a_sqrt_done_waited, sqrt_done, state == ttb_pkg::ST_SQRT_WAIT,
    "square root finished outside its wait state")
  `TTB_ASSERT_NOW(a_div_done_waited, div_done, state == ttb_pkg::ST_DIV_WAIT,
    "divider finished outside its wait state")
  `TTB_ASSERT_NEXT(a_finish_loads, state == ttb_pkg::ST_FINISH && out_free,
    out_valid && state == ttb_pkg::ST_IDLE, "finished face not presented")
  `TTB_ASSERT_NOW(a_degenerate_zero, out_valid && degenerate,
    tangent_x == '0 && tangent_y == '0 && tangent_z == '0 && binormal_x == '0,
    "degenerate result with nonzero vector")

endmodule

`default_nettype wire

// ===== rtl/ttb_mul.sv =====
// ----------------------------------------------------------------------------
// ttb_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ttb_pkg::MUL_W-1:0]     mcand,
  input  logic [ttb_pkg::MUL_W-1:0]     mplier,
  output logic                          done,
  output logic [2*ttb_pkg::MUL_W-1:0]   prod
);

  localparam int MW = ttb_pkg::MUL_W;
  localparam int CW = $clog2(MW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [MW-1:0] hi;
  logic [MW-1:0] lo;
  logic [MW-1:0] mc;
  logic [MW:0]   sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mc} : {(MW + 1){1'b0}});
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi <= '0;
      lo <= mplier;
      mc <= mcand;
    end else if (busy) begin
      {hi, lo} <= {sum, lo[MW-1:1]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ttb_sqrt.sv =====
// ----------------------------------------------------------------------------
// ttb_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ttb_pkg::SUM_W-1:0]  radicand,
  output logic                       done,
  output logic [ttb_pkg::RT_W-1:0]   root
);

  localparam int SW = ttb_pkg::SUM_W;
  localparam int RW = ttb_pkg::RT_W;
  localparam int MW = RW + 4;
  localparam int CW = $clog2(RW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [SW-1:0] src;
  logic [MW-1:0] rem;
  logic [MW-1:0] rem_sh;
  logic [MW-1:0] trial;
  logic          ge;

  assign rem_sh = {rem[MW-3:0], src[SW-1:SW-2]};
  assign trial  = MW'({root, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src  <= {src[SW-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[RW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ttb_div.sv =====
// ----------------------------------------------------------------------------
// ttb_div
// Restoring divider for m * 2^15 / L with m <= L, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ttb_pkg::NORM_BITS-1:0]  num,
  input  logic [ttb_pkg::RT_W-1:0]       den,
  output logic                           done,
  output logic [ttb_pkg::QUO_W-1:0]      quo
);

  localparam int RW = ttb_pkg::RT_W;
  localparam int QW = ttb_pkg::QUO_W;
  localparam int CW = $clog2(QW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [RW:0]   rem;
  logic [RW-1:0] dv;
  logic [RW:0]   r1;
  logic          ge;

  assign ge = (rem >= {1'b0, dv});
  assign r1 = ge ? (rem - {1'b0, dv}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shifted remainder stays below twice the divisor after the first step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= (RW + 1)'(num);
      dv  <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= {r1[RW-1:0], 1'b0};
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_binormal testbench
// Streams triangle-list vertices into the block, predicts each face's Q1.14
// tangent and binormal with an exact integer model, and checks every result
// in order. Covers directed extremes, degenerate faces, random faces, random
// idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1500;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic signed [ttb_pkg::POS_W-1:0] px, py, pz;
    logic [ttb_pkg::TEX_W-1:0] u, v;
  } vertex_t;

  typedef struct packed {
    logic signed [ttb_pkg::OUT_W-1:0] tx, ty, tz, bx, by, bz;
    logic degen;
  } basis_t;

  // exact Q1.14 normalization; returns 0 for a zero vector
  function automatic bit unit_vector(input longint c[3], output logic [15:0] q[3]);
    logic [63:0] mag[3], m[3], sum, rest, res, bitv;
    bit ng[3];
    int lens[3], maxlen, sh;
    maxlen = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = c[i] < 0;
      mag[i] = ng[i] ? -c[i] : c[i];
      lens[i] = 0;
      for (int b = 0; b < 64; b++) if (mag[i][b]) lens[i] = b + 1;
      if (lens[i] > maxlen) maxlen = lens[i];
    end
    if (maxlen == 0) return 0;
    sh = maxlen - ttb_pkg::NORM_BITS;
    for (int i = 0; i < 3; i++) begin
      m[i] = (sh > 0) ? (mag[i] >> sh) : (mag[i] << (-sh));
      sum += m[i] * m[i];
    end
    rest = sum;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > rest) bitv >>= 2;
    while (bitv != 0) begin
      if (rest >= res + bitv) begin
        rest -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (res == 0) return 0;
    for (int i = 0; i < 3; i++) begin
      logic [63:0] qq;
      qq = ((m[i] << 15) / res + 1) >> 1;
      q[i] = ng[i] ? 16'(-qq) : 16'(qq);
    end
    return 1;
  endfunction

  class face_scoreboard;
    vertex_t v0, v1;
    ttb_pkg::phase_t phase;
    basis_t pending[$];
    int errors;

    function new();
      phase = ttb_pkg::PH_FIRST;
      errors = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    function void note_vertex(vertex_t vx);
      longint e1[3], e2[3], tn[3], bn[3], du1, dv1, du2, dv2, det;
      logic [15:0] tq[3], bq[3];
      basis_t r;
      if (phase == ttb_pkg::PH_SECOND) begin
        v1 = vx;
        phase = ttb_pkg::PH_THIRD;
        return;
      end
      if (phase != ttb_pkg::PH_THIRD) begin
        v0 = vx;
        phase = ttb_pkg::PH_SECOND;
        return;
      end
      phase = ttb_pkg::PH_FIRST;
      e1[0] = longint'(v1.px) - longint'(v0.px);
      e1[1] = longint'(v1.py) - longint'(v0.py);
      e1[2] = longint'(v1.pz) - longint'(v0.pz);
      e2[0] = longint'(vx.px) - longint'(v0.px);
      e2[1] = longint'(vx.py) - longint'(v0.py);
      e2[2] = longint'(vx.pz) - longint'(v0.pz);
      du1 = longint'(v1.u) - longint'(v0.u);
      dv1 = longint'(v1.v) - longint'(v0.v);
      du2 = longint'(vx.u) - longint'(v0.u);
      dv2 = longint'(vx.v) - longint'(v0.v);
      det = du1 * dv2 - du2 * dv1;
      r = '0;
      r.degen = 1'b1;
      if (det != 0) begin
        for (int i = 0; i < 3; i++) begin
          tn[i] = dv2 * e1[i] - dv1 * e2[i];
          bn[i] = du1 * e2[i] - du2 * e1[i];
          if (det < 0) begin
            tn[i] = -tn[i];
            bn[i] = -bn[i];
          end
        end
        if (unit_vector(tn, tq) && unit_vector(bn, bq)) begin
          r = {tq[0], tq[1], tq[2], bq[0], bq[1], bq[2], 1'b0};
        end
      end
      pending.push_back(r);
    endfunction

    task check_result(basis_t got);
      basis_t want;
      if (pending.size() == 0) begin
        report("result with no face outstanding", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.tx !== want.tx) report("tangent_x", got.tx, want.tx);
      if (got.ty !== want.ty) report("tangent_y", got.ty, want.ty);
      if (got.tz !== want.tz) report("tangent_z", got.tz, want.tz);
      if (got.bx !== want.bx) report("binormal_x", got.bx, want.bx);
      if (got.by !== want.by) report("binormal_y", got.by, want.by);
      if (got.bz !== want.bz) report("binormal_z", got.bz, want.bz);
      if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
    endtask
  endclass

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  logic signed [ttb_pkg::POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [ttb_pkg::TEX_W-1:0] tex_u = '0, tex_v = '0;
  logic signed [ttb_pkg::OUT_W-1:0] tangent_x, tangent_y, tangent_z;
  logic signed [ttb_pkg::OUT_W-1:0] binormal_x, binormal_y, binormal_z;
  logic degenerate;

  face_scoreboard faces = new();
  int tx_idle_pct = 0, rx_idle_pct = 0;
  bit rx_hold = 0;
  longint cycles = 0;

  triangle_tangent_binormal dut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_tangent_binormal regression: fail");
      $finish;
    end
    if (!rst && in_valid && in_ready) faces.note_vertex({pos_x, pos_y, pos_z, tex_u, tex_v});
    if (!rst && out_valid && out_ready)
      faces.check_result({tangent_x, tangent_y, tangent_z,
                          binormal_x, binormal_y, binormal_z, degenerate});
  end

  always @(negedge clk)
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

  task automatic send_vertex(vertex_t vx);
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    {pos_x, pos_y, pos_z, tex_u, tex_v} = vx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_face(vertex_t a, vertex_t b, vertex_t c);
    send_vertex(a);
    send_vertex(b);
    send_vertex(c);
  endtask

  function automatic vertex_t any_vertex();
    return {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // vertex near a base point, small edges and texture steps
  function automatic vertex_t near_vertex(vertex_t b, int spread);
    vertex_t r;
    r = b;
    r.px += 16'($urandom_range(2 * spread) - spread);
    r.py += 16'($urandom_range(2 * spread) - spread);
    r.pz += 16'($urandom_range(2 * spread) - spread);
    r.u += 16'($urandom_range(2 * spread) - spread);
    r.v += 16'($urandom_range(2 * spread) - spread);
    return r;
  endfunction

  localparam logic signed [15:0] PMAX = 16'sh7FFF, PMIN = 16'sh8000;

  initial begin
    vertex_t a;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // extremes of position and texture
    send_face({PMIN, PMIN, PMIN, 16'h0000, 16'h0000},
              {PMAX, PMIN, PMIN, 16'hFFFF, 16'h0000},
              {PMIN, PMAX, PMAX, 16'h0000, 16'hFFFF});
    send_face({PMAX, PMAX, PMAX, 16'hFFFF, 16'hFFFF},
              {PMIN, PMAX, PMIN, 16'h0000, 16'hFFFF},
              {PMAX, PMIN, PMAX, 16'hFFFF, 16'h0000});
    // zero determinant: identical texture coordinates
    send_face({16'sd0, 16'sd0, 16'sd0, 16'h1234, 16'h5678},
              {16'sd256, 16'sd0, 16'sd0, 16'h1234, 16'h5678},
              {16'sd0, 16'sd256, 16'sd0, 16'h1234, 16'h5678});
    // zero vectors: coincident positions
    send_face({16'sd100, 16'sd100, 16'sd100, 16'h0000, 16'h0000},
              {16'sd100, 16'sd100, 16'sd100, 16'h0100, 16'h0000},
              {16'sd100, 16'sd100, 16'sd100, 16'h0000, 16'h0100});
    // plain unit face with a positive determinant, then a mirrored one with a negative determinant
    send_face({16'sd0, 16'sd0, 16'sd0, 16'h0000, 16'h0000},
              {16'sd256, 16'sd0, 16'sd0, 16'h0100, 16'h0000},
              {16'sd0, 16'sd256, 16'sd0, 16'h0000, 16'h0100});
    send_face({16'sd0, 16'sd0, 16'sd0, 16'h0000, 16'h0000},
              {16'sd256, 16'sd0, 16'sd0, 16'h0000, 16'h0100},
              {16'sd0, 16'sd256, 16'sd0, 16'h0100, 16'h0000});
    // tiny edges
    send_face({16'sd1, 16'sd0, 16'sd0, 16'h0001, 16'h0000},
              {16'sd0, 16'sd1, 16'sd0, 16'h0000, 16'h0001},
              {16'sd0, 16'sd0, 16'sd1, 16'h0001, 16'h0001});

    for (int i = 0; i < N_RANDOM / 3; i++) begin
      if (i == N_RANDOM / 9) begin
        tx_idle_pct = 53;
        rx_idle_pct = 21;
      end else if (i == 2 * N_RANDOM / 9) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (i == 0) begin
        tx_idle_pct = 21;
        rx_idle_pct = 53;
      end
      case ($urandom_range(9))
        0, 1, 2: send_face(any_vertex(), any_vertex(), any_vertex());
        3: begin
          a = any_vertex();
          send_face(a, near_vertex(a, 0) ^ {48'h0, 32'($urandom)}, any_vertex());
        end
        4: begin
          // collinear texture deltas
          a = any_vertex();
          send_face(a, {48'(any_vertex() >> 32), a.u + 16'd7, a.v + 16'd3},
                    {48'(any_vertex() >> 32), a.u + 16'd14, a.v + 16'd6});
        end
        default: begin
          a = any_vertex();
          send_face(a, near_vertex(a, 1 << $urandom_range(8)),
                    near_vertex(a, 1 << $urandom_range(8)));
        end
      endcase
    end
    while (faces.pending.size() != 0) @(negedge clk);
    repeat (1000) @(negedge clk);
    if (faces.errors == 0) $display("triangle_tangent_binormal regression: pass");
    else $display("triangle_tangent_binormal regression: fail");
    $finish;
  end

  // long output stall so the block backs up and refuses vertices
  initial begin
    int held;
    wait (faces.pending.size() >= 1);
    rx_hold = 1;
    held = 0;
    while (held < 4000) begin
      @(negedge clk);
      held++;
    end
    rx_hold = 0;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/ttb_pkg.sv
rtl/ttb_mul.sv
rtl/ttb_sqrt.sv
rtl/ttb_div.sv
rtl/triangle_tangent_binormal.sv
sim/tb_top.sv
